### src/vwnp_pkg.sv
`default_nettype none

package vwnp_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int COORD_WIDTH = 24;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int SQ_W        = 2 * COORD_WIDTH;
	localparam int DIST_W      = SQ_W + 2;
	localparam int CFG_W       = 16;
	localparam int LIMIT_W     = 2 * CFG_W;
	localparam int ENTRY_W     = 3 * COORD_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

### src/vwnp_ram.sv
`default_nettype none

module vwnp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/vwnp_dist.sv
`default_nettype none

module vwnp_dist import vwnp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire point_t            pt,
	input  wire point_t            vtx,
	output logic                   out_valid,
	output logic [DIST_W-1:0]      sq_dist,
	output point_t                 out_pt,
	output logic                   busy
);

	function automatic logic [COORD_WIDTH-1:0] abs_diff(coord_t a, coord_t b);
		logic [COORD_WIDTH:0] d;
		d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		if (d[COORD_WIDTH]) begin
			d = -d;
		end
		return d[COORD_WIDTH-1:0];
	endfunction

	logic                   v_s2, v_s3, v_s4;
	logic [COORD_WIDTH-1:0] adx_s2, ady_s2, adz_s2;
	logic [SQ_W-1:0]        sqx_s3, sqy_s3, sqz_s3;
	logic [DIST_W-1:0]      dist_s4;
	point_t                 pt_s2, pt_s3, pt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		adx_s2  <= abs_diff(pt.x, vtx.x);
		ady_s2  <= abs_diff(pt.y, vtx.y);
		adz_s2  <= abs_diff(pt.z, vtx.z);
		pt_s2   <= pt;
		sqx_s3  <= adx_s2 * adx_s2;
		sqy_s3  <= ady_s2 * ady_s2;
		sqz_s3  <= adz_s2 * adz_s2;
		pt_s3   <= pt_s2;
		dist_s4 <= DIST_W'(sqx_s3) + DIST_W'(sqy_s3) + DIST_W'(sqz_s3);
		pt_s4   <= pt_s3;
	end

	assign out_valid = v_s4;
	assign sq_dist   = dist_s4;
	assign out_pt    = pt_s4;
	assign busy      = v_s2 | v_s3 | v_s4;

endmodule

`default_nettype wire

### src/vertex_weld_nearest_point.sv
`default_nettype none

// Vertex welder. Each input item is one vertex (pos_x, pos_y, pos_z). The block
// compares it against every kept point and returns one result item: the nearest
// kept point if it lies within the snap distance (snapped, and moved if it
// differs), else the vertex itself, which is appended to the store while there
// is room (dropped when the store is full).
// Channels: in_valid/in_ready and out_valid/out_ready; the snap distance is
// written through cfg_wen/cfg_wdata; the user writes it only while the block is idle, which the block does not enforce.
// Order: an item that finds the store empty goes straight to ST_FIN; otherwise the
// scan reads the point memory one entry per cycle through its single read port,
// and ST_FIN follows once the distance pipeline has drained. A new item is taken
// only in ST_IDLE, so the block finishes one item before it accepts the next.
// A result waits in the output register while out_ready is low; the next item
// is still accepted and scanned, and stalls only when its own result is ready.
// Reset empties the store (the count goes to zero; the memory is not cleared)
// and sets the snap distance to zero.
module vertex_weld_nearest_point import vwnp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_wen,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] pos_x,
	input  wire logic signed [COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [COORD_WIDTH-1:0] pos_z,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                         snapped,
	output logic                         moved,
	output logic                         dropped
);

	state_t             state_q;
	logic [CFG_W-1:0]   max_dist_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  rd_idx_q;
	logic               issuing_q;
	logic               v_s1;
	logic               found_q;
	logic [DIST_W-1:0]  best_q;
	point_t             best_pt_q;
	point_t             pos_q;

	logic               accept;
	logic               last_issue;
	logic               snap;
	logic               is_moved;
	logic               room;
	logic               fin_fire;
	logic               ram_we;
	logic [ENTRY_W-1:0] ram_rdata;
	point_t             rd_pt;
	logic               d_valid;
	logic [DIST_W-1:0]  d_dist;
	point_t             d_pt;
	logic               d_busy;
	logic               better;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign last_issue = (CNT_W'(rd_idx_q) + CNT_W'(1)) == cnt_q;
	assign snap       = found_q && (best_q <= DIST_W'(limit_q));
	assign is_moved   = snap && (best_pt_q != pos_q);
	assign room       = cnt_q < CNT_W'(STORE_DEPTH);
	assign fin_fire   = (state_q == ST_FIN) && (!out_valid || out_ready);
	assign ram_we     = fin_fire && !snap && room;
	assign rd_pt      = ram_rdata;
	assign better     = d_valid && (!found_q || d_dist < best_q);

	vwnp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(pos_q),
		.re   (issuing_q),
		.raddr(rd_idx_q),
		.rdata(ram_rdata)
	);

	vwnp_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.pt       (rd_pt),
		.vtx      (pos_q),
		.out_valid(d_valid),
		.sq_dist  (d_dist),
		.out_pt   (d_pt),
		.busy     (d_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			max_dist_q <= '0;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			issuing_q  <= 1'b0;
			v_s1       <= 1'b0;
			found_q    <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_dist_q <= cfg_wdata;
			end
			v_s1 <= issuing_q;
			if (better) begin
				found_q <= 1'b1;
			end
			if (fin_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						found_q  <= 1'b0;
						rd_idx_q <= '0;
						if (cnt_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							issuing_q <= 1'b1;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						rd_idx_q <= rd_idx_q + ADDR_W'(1);
						if (last_issue) begin
							issuing_q <= 1'b0;
						end
					end else if (!v_s1 && !d_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= '{x: pos_x, y: pos_y, z: pos_z};
			limit_q <= max_dist_q * max_dist_q;
		end
		// strict compare keeps the earliest point on a tie
		if (better) begin
			best_q    <= d_dist;
			best_pt_q <= d_pt;
		end
		if (fin_fire) begin
			out_x   <= snap ? best_pt_q.x : pos_q.x;
			out_y   <= snap ? best_pt_q.y : pos_q.y;
			out_z   <= snap ? best_pt_q.z : pos_q.z;
			snapped <= snap;
			moved   <= is_moved;
			dropped <= !snap && !room;
		end
	end

endmodule

`default_nettype wire

### src/vwnp_checker.sv
`default_nettype none

module vwnp_checker import vwnp_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [COORD_WIDTH-1:0] out_x,
	input wire logic signed [COORD_WIDTH-1:0] out_y,
	input wire logic signed [COORD_WIDTH-1:0] out_z,
	input wire logic                    snapped,
	input wire logic                    moved,
	input wire logic                    dropped
);

	// a stalled result must hold
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(snapped) && $stable(moved) && $stable(dropped))
		else $error("result changed while stalled");

	a_moved_snap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && moved |-> snapped)
		else $error("moved without snap");

	a_drop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !snapped && !moved)
		else $error("dropped item also snapped");

	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken during a scan");

endmodule

bind vertex_weld_nearest_point vwnp_checker u_vwnp_checker (.*);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import vwnp_pkg::*;

	localparam int MAXC = 8388607;
	localparam int MINC = -8388608;
	localparam int QUIET_LIMIT = 30000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 64;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   snapped;
		logic   moved;
		logic   dropped;
	} weld_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	coord_t pos_x = '0;
	coord_t pos_y = '0;
	coord_t pos_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic snapped;
	logic moved;
	logic dropped;

	// predictor state
	point_t kept_pts [STORE_DEPTH];
	int kept_cnt = 0;
	logic [CFG_W-1:0] snap_dist = '0;

	point_t vtx_queue [$];
	point_t issued [$];
	weld_t welds [$];
	point_t drv_pt;
	point_t seen_pt;
	weld_t want;
	bit item_taken = 1'b0;
	bit steady_run = 1'b0;
	int quiet_cycles = 0;
	int fail_cnt = 0;
	int n_items = 0;
	int n_snap = 0;
	int n_moved = 0;
	int n_drop = 0;
	int n_settings = 0;

	vertex_weld_nearest_point DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.snapped   (snapped),
		.moved     (moved),
		.dropped   (dropped)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned axis_sq(coord_t a, coord_t b);
		longint d;
		longint unsigned m;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		m = d;
		if (m > 64'h8000_0000)
			m = 64'h8000_0000;
		return m * m;
	endfunction

	// nearest kept point wins; on a tie the earliest kept one stays
	function automatic weld_t weld_predict(point_t v);
		weld_t r;
		longint unsigned best;
		longint unsigned d;
		longint unsigned lim;
		int best_i;
		int i;
		bit found;
		best = 0;
		best_i = 0;
		found = 1'b0;
		lim = longint'(snap_dist) * longint'(snap_dist);
		for (i = 0; i < kept_cnt; i++) begin
			d = axis_sq(kept_pts[i].x, v.x) + axis_sq(kept_pts[i].y, v.y)
				+ axis_sq(kept_pts[i].z, v.z);
			if (!found || d < best) begin
				best = d;
				best_i = i;
				found = 1'b1;
			end
		end
		r.x = v.x;
		r.y = v.y;
		r.z = v.z;
		r.snapped = 1'b0;
		r.moved = 1'b0;
		r.dropped = 1'b0;
		if (found && best <= lim) begin
			r.x = kept_pts[best_i].x;
			r.y = kept_pts[best_i].y;
			r.z = kept_pts[best_i].z;
			r.snapped = 1'b1;
			r.moved = (r.x != v.x) || (r.y != v.y) || (r.z != v.z);
		end else if (kept_cnt < STORE_DEPTH) begin
			kept_pts[kept_cnt] = v;
			kept_cnt++;
		end else begin
			r.dropped = 1'b1;
		end
		n_items++;
		n_snap += r.snapped;
		n_moved += r.moved;
		n_drop += r.dropped;
		return r;
	endfunction

	task automatic check_field(string name, logic signed [31:0] exp_v,
			logic signed [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fail_cnt++;
		end
	endtask

	// driver: hold the item until it is taken, then advance or idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			item_taken = 1'b0;
			if (vtx_queue.size() != 0 && (steady_run || $urandom_range(0, 99) >= 17)) begin
				drv_pt = vtx_queue.pop_front();
				in_valid <= 1'b1;
				pos_x <= drv_pt.x;
				pos_y <= drv_pt.y;
				pos_z <= drv_pt.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && (steady_run || $urandom_range(0, 99) >= 17);
	end

	// monitor: check results first, then predict the newly taken item
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (welds.size() == 0) begin
				$error("result item with no vertex pending");
				fail_cnt++;
			end else begin
				want = welds.pop_front();
				check_field("out_x", want.x, out_x);
				check_field("out_y", want.y, out_y);
				check_field("out_z", want.z, out_z);
				check_field("snapped", want.snapped, snapped);
				check_field("moved", want.moved, moved);
				check_field("dropped", want.dropped, dropped);
			end
		end
		if (in_valid && in_ready) begin
			seen_pt = {pos_x, pos_y, pos_z};
			welds.push_back(weld_predict(seen_pt));
			item_taken = 1'b1;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic push_vtx(int x, int y, int z);
		point_t p;
		p.x = coord_t'(x);
		p.y = coord_t'(y);
		p.z = coord_t'(z);
		vtx_queue.push_back(p);
		issued.push_back(p);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (vtx_queue.size() != 0 || in_valid || welds.size() != 0);
	endtask

	task automatic set_snap_dist(int value);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= CFG_W'(value);
		snap_dist = CFG_W'(value);
		n_settings++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic int any_coord();
		logic [31:0] r;
		r = $urandom();
		return int'(coord_t'(r[COORD_WIDTH-1:0]));
	endfunction

	function automatic int nudge(coord_t c, int span);
		int t;
		t = int'(c) + int'($urandom_range(0, 2 * span)) - span;
		if (t > MAXC)
			t = MAXC;
		if (t < MINC)
			t = MINC;
		return t;
	endfunction

	// one vertex near an earlier one, in a small cluster, or anywhere
	task automatic push_mixed(int span_max);
		point_t b;
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		if (pick < 55 && issued.size() != 0) begin
			b = issued[$urandom_range(0, issued.size() - 1)];
			span = ($urandom_range(0, 99) < 15) ? 0 :
				(span_max == 0) ? int'($urandom_range(0, 1)) : span_max;
			push_vtx(nudge(b.x, span), nudge(b.y, span), nudge(b.z, span));
		end else if (pick < 75) begin
			push_vtx(int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
				int'($urandom_range(0, 600)) - 300);
		end else begin
			push_vtx(any_coord(), any_coord(), any_coord());
		end
	endtask

	initial begin
		int ph;
		int k;
		int md;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// exact matches only; empty store, extremes, corner mixes
		set_snap_dist(0);
		push_vtx(0, 0, 0);
		push_vtx(0, 0, 0);
		push_vtx(2, 0, 0);
		push_vtx(MAXC, MAXC, MAXC);
		push_vtx(MINC, MINC, MINC);
		push_vtx(MINC, MAXC, MINC);
		push_vtx(MAXC, MINC, 0);
		drain();

		// tie between two kept points, and the boundary at exactly the snap distance
		set_snap_dist(5);
		push_vtx(1, 0, 0);
		push_vtx(0, 3, 0);
		push_vtx(MAXC, MAXC, MAXC - 5);
		push_vtx(MAXC, MAXC, MAXC - 6);
		push_vtx(MINC, MINC, MINC + 5);
		push_vtx(MINC + 3, MINC + 4, MINC);
		drain();

		set_snap_dist(65535);
		push_vtx(-65535, 0, 0);
		push_vtx(-65536, 0, 0);
		push_vtx(0, -65535, 1);
		push_vtx(MAXC - 30000, MAXC - 30000, MAXC - 30000);
		drain();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				md = 1;
			else if (ph == 1)
				md = 65535;
			else if (ph == 2)
				md = 0;
			else if (ph % 2)
				md = $urandom_range(2, 60);
			else
				md = $urandom_range(61, 65535);
			set_snap_dist(md);
			steady_run = (ph == 4);
			for (k = 0; k < PHASE_ITEMS; k++)
				push_mixed(md);
			drain();
		end
		steady_run = 1'b0;

		// grown store: near vertices snap at a wider distance, then exact matches only
		set_snap_dist(200);
		push_vtx(MAXC, MAXC, MAXC);
		for (k = 0; k < 40; k++)
			push_mixed(200);
		drain();
		set_snap_dist(0);
		for (k = 0; k < 20; k++)
			push_mixed(0);
		drain();

		repeat (1100) @(posedge clk);
		$display("Covered %0d vertices under %0d snap distance settings; kept %0d of %0d.",
			n_items, n_settings, kept_cnt, STORE_DEPTH);
		$display("Results: %0d snapped (%0d moved), %0d dropped while the store was full.",
			n_snap, n_moved, n_drop);
		if (fail_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
